[rtl/core/weighted_fixed_window_rate_limiter_macros.svh]
// Assertion macros used by the checker of the rate limiter.
`ifndef WEIGHTED_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH
`define WEIGHTED_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFWRL_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rate limiter check failed");

// The consequent must hold in the cycle after the antecedent.
`define WFWRL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rate limiter check failed");

`endif

[rtl/core/wfwrl_pkg.sv]
package wfwrl_pkg;

   localparam int TIME_BITS_DEF  = 32;
   localparam int COUNT_BITS_DEF = 32;

   localparam int FUNC_W      = 2;
   localparam int WEIGHT_W    = 16;
   localparam int CFG_W       = 32;
   localparam int ELAPSED_W   = 32;
   localparam int USED_W      = 32;
   localparam int TOTAL_W     = 48;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_REQUEST = 2'd1,
      FUNC_ORDER   = 2'd2
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REQUEST_WEIGHT_LIMIT   = 3'd0,
      CSR_REQUEST_WINDOW_SECONDS = 3'd1,
      CSR_ORDER_SHORT_LIMIT      = 3'd2,
      CSR_ORDER_SHORT_SECONDS    = 3'd3,
      CSR_ORDER_LONG_LIMIT       = 3'd4,
      CSR_ORDER_LONG_SECONDS     = 3'd5
   } csr_index_type;

   localparam logic [CFG_W-1:0] REQUEST_WEIGHT_LIMIT_RST   = 32'd1200;
   localparam logic [CFG_W-1:0] REQUEST_WINDOW_SECONDS_RST = 32'd60;
   localparam logic [CFG_W-1:0] ORDER_SHORT_LIMIT_RST      = 32'd10;
   localparam logic [CFG_W-1:0] ORDER_SHORT_SECONDS_RST    = 32'd1;
   localparam logic [CFG_W-1:0] ORDER_LONG_LIMIT_RST       = 32'd100000;
   localparam logic [CFG_W-1:0] ORDER_LONG_SECONDS_RST     = 32'd86400;

endpackage

[rtl/core/wfwrl_req_if.sv]
interface wfwrl_req_if;
   import wfwrl_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [WEIGHT_W-1:0] weight;

   modport source (output valid, output func, output weight, input ready);
   modport sink (input valid, input func, input weight, output ready);
endinterface

[rtl/core/wfwrl_rsp_if.sv]
interface wfwrl_rsp_if;
   import wfwrl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 granted;
   logic [ELAPSED_W-1:0] elapsed_main;
   logic [ELAPSED_W-1:0] elapsed_long;
   logic [USED_W-1:0]    window_used;
   logic [TOTAL_W-1:0]   total_used;

   modport source (output valid, output granted, output elapsed_main, output elapsed_long,
                   output window_used, output total_used, input ready);
   modport sink (input valid, input granted, input elapsed_main, input elapsed_long,
                 input window_used, input total_used, output ready);
endinterface

[rtl/core/weighted_fixed_window_rate_limiter.sv]
// Weighted fixed-window rate limiter with a request window and a short and
// a long order window.
// The req channel carries one transaction per tick, request call or order
// call; the rsp channel returns exactly one transaction for each, in order:
// the admission decision, the elapsed window times and the usage counters.
// Both channels use a valid/ready handshake. The csr port writes the six
// limit and window length registers and must only be used while idle.
// A transaction taken into the input register is decided when it moves on,
// and its result enters the output register; a stall can hold it in between.
// Throughput is one transaction per cycle while the receiver takes results,
// set by the single decision stage that reads and updates the window state.
// While the receiver stalls, the result is held, the input register still
// takes one more transaction, and then req.ready drops.
// Synchronous reset restores the register defaults, clears all windows,
// totals and the second counter, and empties both pipeline registers.
module weighted_fixed_window_rate_limiter #(
   parameter int TIME_BITS  = wfwrl_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = wfwrl_pkg::COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   wfwrl_req_if.sink                            req,
   wfwrl_rsp_if.source                          rsp,
   input  logic                                 csr_we,
   input  logic [wfwrl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wfwrl_pkg::CFG_W-1:0]          csr_wdata
);
   import wfwrl_pkg::*;

   localparam int TW  = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
   localparam int CW  = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;
   localparam int CP1 = COUNT_BITS + 1;
   localparam int TP1 = TOTAL_W + 1;

   function automatic logic [COUNT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] a,
                                                       input logic [WEIGHT_W-1:0] w);
      logic [CP1-1:0] s;
      s = {1'b0, a} + CP1'(w);
      return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_total(input logic [TOTAL_W-1:0] a,
                                                    input logic [WEIGHT_W-1:0] w);
      logic [TP1-1:0] s;
      s = {1'b0, a} + TP1'(w);
      return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
   endfunction

   logic [CFG_W-1:0] req_limit_ff, req_seconds_ff;
   logic [CFG_W-1:0] short_limit_ff, short_seconds_ff;
   logic [CFG_W-1:0] long_limit_ff, long_seconds_ff;

   logic [TIME_BITS-1:0]  seconds_now_ff, seconds_now_in;
   logic [TIME_BITS-1:0]  req_start_ff, req_start_in;
   logic                  req_started_ff, req_started_in;
   logic [COUNT_BITS-1:0] req_used_ff, req_used_in;
   logic [TOTAL_W-1:0]    req_total_ff, req_total_in;
   logic [TIME_BITS-1:0]  short_start_ff, short_start_in;
   logic                  short_started_ff, short_started_in;
   logic [COUNT_BITS-1:0] short_used_ff, short_used_in;
   logic [TOTAL_W-1:0]    short_total_ff, short_total_in;
   logic [TIME_BITS-1:0]  long_start_ff, long_start_in;
   logic                  long_started_ff, long_started_in;
   logic [COUNT_BITS-1:0] long_used_ff, long_used_in;
   logic [TOTAL_W-1:0]    long_total_ff, long_total_in;

   logic                in_valid_ff;
   logic [FUNC_W-1:0]   in_func_ff;
   logic [WEIGHT_W-1:0] in_weight_ff;

   logic                 out_valid_ff;
   logic                 out_granted_ff, out_granted_in;
   logic [ELAPSED_W-1:0] out_el_main_ff, out_el_main_in;
   logic [ELAPSED_W-1:0] out_el_long_ff, out_el_long_in;
   logic [USED_W-1:0]    out_used_ff, out_used_in;
   logic [TOTAL_W-1:0]   out_total_ff, out_total_in;

   logic advance;
   logic accept_in;

   logic [TIME_BITS-1:0] req_span, short_span, long_span;
   logic [TW-1:0]        req_span_x, short_span_x, long_span_x;
   logic                 req_deny, req_clear;
   logic                 short_deny, short_clear;
   logic                 long_over, long_clear;
   logic                 high_block;
   logic [COUNT_BITS-1:0] short_base, long_base, req_base;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign accept_in = req.valid && req.ready;

   assign rsp.valid        = out_valid_ff;
   assign rsp.granted      = out_granted_ff;
   assign rsp.elapsed_main = out_el_main_ff;
   assign rsp.elapsed_long = out_el_long_ff;
   assign rsp.window_used  = out_used_ff;
   assign rsp.total_used   = out_total_ff;

   // A window that has not started yet opens now, so its span is zero.
   assign req_span   = req_started_ff   ? seconds_now_ff - req_start_ff   : '0;
   assign short_span = short_started_ff ? seconds_now_ff - short_start_ff : '0;
   assign long_span  = long_started_ff  ? seconds_now_ff - long_start_ff  : '0;

   assign req_span_x   = TW'(req_span);
   assign short_span_x = TW'(short_span);
   assign long_span_x  = TW'(long_span);

   assign req_deny = (req_span_x < TW'(req_seconds_ff))
                     && ((CW'(req_used_ff) + CW'(in_weight_ff)) > CW'(req_limit_ff));
   assign req_clear = (req_span_x > TW'(req_seconds_ff))
                      && (CW'(req_used_ff) < CW'(req_limit_ff));
   assign short_deny = (short_span_x < TW'(short_seconds_ff))
                       && ((CW'(short_used_ff) + CW'(in_weight_ff)) > CW'(short_limit_ff));
   assign short_clear = (short_span_x > TW'(short_seconds_ff))
                        && (CW'(short_used_ff) < CW'(short_limit_ff));
   assign long_over  = (long_span_x < TW'(long_seconds_ff))
                       && (CW'(long_used_ff) > CW'(long_limit_ff));
   assign long_clear = long_span_x > TW'(long_seconds_ff);
   assign high_block = long_over && !long_clear;

   assign req_base   = req_clear   ? '0 : req_used_ff;
   assign short_base = short_clear ? '0 : short_used_ff;
   assign long_base  = long_clear  ? '0 : long_used_ff;

   always_comb begin
      seconds_now_in   = seconds_now_ff;
      req_start_in     = req_start_ff;
      req_started_in   = req_started_ff;
      req_used_in      = req_used_ff;
      req_total_in     = req_total_ff;
      short_start_in   = short_start_ff;
      short_started_in = short_started_ff;
      short_used_in    = short_used_ff;
      short_total_in   = short_total_ff;
      long_start_in    = long_start_ff;
      long_started_in  = long_started_ff;
      long_used_in     = long_used_ff;
      long_total_in    = long_total_ff;
      out_granted_in   = 1'b0;
      out_el_main_in   = '0;
      out_el_long_in   = '0;
      out_used_in      = '0;
      out_total_in     = '0;
      unique case (func_type'(in_func_ff))
         FUNC_TICK: begin
            seconds_now_in = seconds_now_ff + TIME_BITS'(1);
         end
         FUNC_REQUEST: begin
            req_started_in = 1'b1;
            req_start_in   = req_started_ff ? req_start_ff : seconds_now_ff;
            out_el_main_in = req_span_x[ELAPSED_W-1:0];
            if (!req_deny) begin
               if (req_clear) begin
                  req_started_in = 1'b0;
               end
               req_used_in    = sat_count(req_base, in_weight_ff);
               req_total_in   = sat_total(req_total_ff, in_weight_ff);
               out_granted_in = 1'b1;
            end
            out_used_in  = USED_W'(req_used_in);
            out_total_in = req_total_in;
         end
         FUNC_ORDER: begin
            short_started_in = 1'b1;
            short_start_in   = short_started_ff ? short_start_ff : seconds_now_ff;
            long_started_in  = 1'b1;
            long_start_in    = long_started_ff ? long_start_ff : seconds_now_ff;
            out_el_main_in   = short_span_x[ELAPSED_W-1:0];
            out_el_long_in   = long_span_x[ELAPSED_W-1:0];
            if (!short_deny) begin
               if (short_clear) begin
                  short_used_in    = '0;
                  short_started_in = 1'b0;
               end
               if (long_clear) begin
                  long_used_in    = '0;
                  long_started_in = 1'b0;
               end
               if (!high_block) begin
                  short_used_in  = sat_count(short_base, in_weight_ff);
                  short_total_in = sat_total(short_total_ff, in_weight_ff);
                  long_used_in   = sat_count(long_base, in_weight_ff);
                  long_total_in  = sat_total(long_total_ff, in_weight_ff);
                  out_granted_in = 1'b1;
               end
            end
            out_used_in  = USED_W'(short_used_in);
            out_total_in = short_total_in;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_limit_ff     <= REQUEST_WEIGHT_LIMIT_RST;
         req_seconds_ff   <= REQUEST_WINDOW_SECONDS_RST;
         short_limit_ff   <= ORDER_SHORT_LIMIT_RST;
         short_seconds_ff <= ORDER_SHORT_SECONDS_RST;
         long_limit_ff    <= ORDER_LONG_LIMIT_RST;
         long_seconds_ff  <= ORDER_LONG_SECONDS_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_REQUEST_WEIGHT_LIMIT:   req_limit_ff     <= csr_wdata;
            CSR_REQUEST_WINDOW_SECONDS: req_seconds_ff   <= csr_wdata;
            CSR_ORDER_SHORT_LIMIT:      short_limit_ff   <= csr_wdata;
            CSR_ORDER_SHORT_SECONDS:    short_seconds_ff <= csr_wdata;
            CSR_ORDER_LONG_LIMIT:       long_limit_ff    <= csr_wdata;
            CSR_ORDER_LONG_SECONDS:     long_seconds_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_now_ff   <= '0;
         req_start_ff     <= '0;
         req_started_ff   <= 1'b0;
         req_used_ff      <= '0;
         req_total_ff     <= '0;
         short_start_ff   <= '0;
         short_started_ff <= 1'b0;
         short_used_ff    <= '0;
         short_total_ff   <= '0;
         long_start_ff    <= '0;
         long_started_ff  <= 1'b0;
         long_used_ff     <= '0;
         long_total_ff    <= '0;
      end else if (advance) begin
         seconds_now_ff   <= seconds_now_in;
         req_start_ff     <= req_start_in;
         req_started_ff   <= req_started_in;
         req_used_ff      <= req_used_in;
         req_total_ff     <= req_total_in;
         short_start_ff   <= short_start_in;
         short_started_ff <= short_started_in;
         short_used_ff    <= short_used_in;
         short_total_ff   <= short_total_in;
         long_start_ff    <= long_start_in;
         long_started_ff  <= long_started_in;
         long_used_ff     <= long_used_in;
         long_total_ff    <= long_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept_in) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_func_ff   <= req.func;
         in_weight_ff <= req.weight;
      end
      if (advance) begin
         out_granted_ff <= out_granted_in;
         out_el_main_ff <= out_el_main_in;
         out_el_long_ff <= out_el_long_in;
         out_used_ff    <= out_used_in;
         out_total_ff   <= out_total_in;
      end
   end

endmodule

[rtl/core/wfwrl_checker.sv]
`include "weighted_fixed_window_rate_limiter_macros.svh"

module wfwrl_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_granted,
   input logic [wfwrl_pkg::TOTAL_W-1:0]    rsp_total_used
);
   import wfwrl_pkg::*;

   logic [1:0] occ_ff, occ_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      occ_in = occ_ff;
      if (req_fire && !rsp_fire) begin
         occ_in = occ_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         occ_in = occ_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // A stalled result transaction must keep its contents.
   `WFWRL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_granted) && $stable(rsp_total_used))

   // While a result is valid, no more than two transactions are inside the block,
   // and no result appears without a pending request.
   `WFWRL_ASSERT_SAME(a_occupancy, clock, reset, rsp_valid, occ_ff != 2'd0 && occ_ff != 2'd3)

   // A receiver that takes results never holds back the request side.
   `WFWRL_ASSERT_SAME(a_flow, clock, reset, rsp_ready, req_ready)

   // The block comes out of reset empty.
   `WFWRL_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid && req_ready)

endmodule

bind weighted_fixed_window_rate_limiter wfwrl_checker u_wfwrl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_granted    (rsp.granted),
   .rsp_total_used (rsp.total_used)
);
